// ----- rtl/core/psfg_pkg.sv -----
// Package: constants and types for the per-source flood guard.
package psfg_pkg;
  localparam int unsigned TableEntries = 32;
  localparam int unsigned IdxW = (TableEntries > 1) ? $clog2(TableEntries) : 1;
  localparam int unsigned CaptureMax = 256;
  localparam int unsigned CapLenW = 9;
  localparam logic [15:0] MinCapturePayload = 16'd10;

  localparam logic [2:0] RegSynWindow  = 3'd0;
  localparam logic [2:0] RegSynLimit   = 3'd1;
  localparam logic [2:0] RegCapacity   = 3'd2;
  localparam logic [2:0] RegRefillRate = 3'd3;
  localparam logic [2:0] RegPacketCost = 3'd4;
  localparam logic [2:0] RegPortA      = 3'd5;
  localparam logic [2:0] RegPortB      = 3'd6;

  localparam logic [1:0] KindTcp   = 2'd2;
  localparam logic [1:0] KindNonTcp = 2'd1;

  localparam logic [1:0] VerdictPass   = 2'd0;
  localparam logic [1:0] VerdictBanned = 2'd1;
  localparam logic [1:0] VerdictSynBan = 2'd2;
  localparam logic [1:0] VerdictNoTok  = 2'd3;

  localparam logic [7:0] TlsHandshake = 8'h16;
  localparam logic [7:0] TlsMajor     = 8'h03;
  localparam logic [7:0] TlsHello     = 8'h01;

  typedef struct packed {
    logic        banned;
    logic        syn_valid;
    logic [15:0] syn_count;
    logic [63:0] window_start;
    logic        bucket_valid;
    logic [15:0] token_count;
    logic [63:0] refill_time;
  } entry_t;

  typedef struct packed {
    logic [31:0] syn_window_ns;
    logic [15:0] syn_limit;
    logic [15:0] bucket_capacity;
    logic [7:0]  refill_rate;
    logic [15:0] packet_cost;
    logic [15:0] guarded_port_a;
    logic [15:0] guarded_port_b;
  } cfg_t;
endpackage

// ----- rtl/core/psfg_update.sv -----
// Per-packet decision and entry update from the matched or free table entry.
module psfg_update (
  input  psfg_pkg::cfg_t   cfg_i,
  input  logic [1:0]       kind_i,
  input  logic [63:0]      now_i,
  input  logic             listed_i,
  input  logic             syn_i,
  input  logic             ack_i,
  input  logic [15:0]      port_i,
  input  logic [15:0]      plen_i,
  input  logic [7:0]       b0_i,
  input  logic [7:0]       b1_i,
  input  logic [7:0]       b5_i,
  input  logic             hit_i,
  input  logic             free_i,
  input  psfg_pkg::entry_t ent_i,
  output logic             take_o,
  output logic             wr_o,
  output psfg_pkg::entry_t ent_o,
  output logic [1:0]       verdict_o,
  output logic             capture_o,
  output logic [8:0]       cap_len_o,
  output logic             tls_o,
  output logic             untracked_o
);
  logic new_syn, guarded, have, fresh;
  logic [63:0] syn_el, tok_el;
  logic [23:0] prod;
  logic [24:0] sum;
  logic [15:0] tok;
  psfg_pkg::entry_t e;
  logic [1:0] v;

  always_comb begin
    new_syn = syn_i && !ack_i;
    guarded = (port_i == cfg_i.guarded_port_a) || (port_i == cfg_i.guarded_port_b);
    v = psfg_pkg::VerdictPass;
    take_o = 1'b0;
    untracked_o = 1'b0;
    fresh = 1'b0;
    e = ent_i;
    tok = '0;
    syn_el = now_i - ent_i.window_start;
    tok_el = now_i - ent_i.refill_time;
    prod = 24'(tok_el[15:0]) * 24'(cfg_i.refill_rate);
    sum = {9'd0, ent_i.token_count} + {1'b0, prod};
    if (listed_i) v = psfg_pkg::VerdictBanned;
    else if ((kind_i == psfg_pkg::KindNonTcp || kind_i == psfg_pkg::KindTcp)
             && hit_i && ent_i.banned) v = psfg_pkg::VerdictBanned;
    have = hit_i;
    if (v == psfg_pkg::VerdictPass && kind_i == psfg_pkg::KindTcp) begin
      if (!hit_i && (new_syn || guarded)) begin
        if (free_i) begin
          take_o = 1'b1;
          have = 1'b1;
          fresh = 1'b1;
        end else untracked_o = 1'b1;
      end
      if (fresh) begin
        e = '0;
      end
      if (have && new_syn) begin
        if (e.syn_valid) begin
          if (syn_el > {32'd0, cfg_i.syn_window_ns}) begin
            e.syn_count = 16'd1;
            e.window_start = now_i;
          end else begin
            if (e.syn_count != 16'hFFFF) e.syn_count = e.syn_count + 16'd1;
            if (e.syn_count > cfg_i.syn_limit) begin
              e.banned = 1'b1;
              v = psfg_pkg::VerdictSynBan;
            end
          end
        end else begin
          e.syn_valid = 1'b1;
          e.syn_count = 16'd1;
          e.window_start = now_i;
        end
      end
      if (v == psfg_pkg::VerdictPass && have && guarded) begin
        if (e.bucket_valid) begin
          if (cfg_i.refill_rate == 8'd0) tok = e.token_count;
          else if (tok_el > 64'hFFFF) tok = cfg_i.bucket_capacity;
          else if (sum > {9'd0, cfg_i.bucket_capacity}) tok = cfg_i.bucket_capacity;
          else tok = sum[15:0];
          if (tok > cfg_i.bucket_capacity) tok = cfg_i.bucket_capacity;
          e.refill_time = now_i;
          if (tok < cfg_i.packet_cost) begin
            e.token_count = tok;
            v = psfg_pkg::VerdictNoTok;
          end else e.token_count = tok - cfg_i.packet_cost;
        end else begin
          e.bucket_valid = 1'b1;
          e.token_count = (cfg_i.bucket_capacity > cfg_i.packet_cost) ?
                          cfg_i.bucket_capacity - cfg_i.packet_cost : 16'd0;
          e.refill_time = now_i;
        end
      end
    end
    wr_o = have && kind_i == psfg_pkg::KindTcp && !listed_i && !(hit_i && ent_i.banned);
    ent_o = e;
    verdict_o = v;
    capture_o = 1'b0;
    cap_len_o = '0;
    tls_o = 1'b0;
    if (v == psfg_pkg::VerdictPass && kind_i == psfg_pkg::KindTcp && guarded
        && plen_i > psfg_pkg::MinCapturePayload) begin
      capture_o = 1'b1;
      cap_len_o = (plen_i > 16'(psfg_pkg::CaptureMax)) ?
                  psfg_pkg::CapLenW'(psfg_pkg::CaptureMax) : plen_i[8:0];
      tls_o = (port_i == cfg_i.guarded_port_b) && b0_i == psfg_pkg::TlsHandshake
              && b1_i == psfg_pkg::TlsMajor && b5_i == psfg_pkg::TlsHello;
    end
    if (v != psfg_pkg::VerdictPass) untracked_o = 1'b0;
  end
endmodule

// ----- rtl/core/per_source_flood_guard.sv -----
// Top level: per-source SYN flood guard with token bucket limiting.
// Timing: the input transaction is captured in the input register and its result
// in the result register.
// Throughput: one transaction per cycle unless the output stalls; the source table
// is written in the cycle the result is registered; the next item sees it unstalled.
// Reset: configuration and valid registers take their reset values, all table entries invalid.
module per_source_flood_guard (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  packet_kind_i,
  input  logic [31:0] src_addr_i,
  input  logic [63:0] time_ns_i,
  input  logic        listed_i,
  input  logic        syn_flag_i,
  input  logic        ack_flag_i,
  input  logic [15:0] dst_port_i,
  input  logic [15:0] payload_len_i,
  input  logic [7:0]  payload_byte0_i,
  input  logic [7:0]  payload_byte1_i,
  input  logic [7:0]  payload_byte5_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  verdict_o,
  output logic        capture_o,
  output logic [8:0]  capture_len_o,
  output logic        tls_hello_o,
  output logic        untracked_o
);
  localparam int unsigned N = psfg_pkg::TableEntries;
  psfg_pkg::cfg_t cfg_q;
  logic [N-1:0] valid_q;
  logic [31:0] addr_q [N];
  psfg_pkg::entry_t ent_q [N];

  logic s1_q;
  logic [1:0] kind_q;
  logic [31:0] src_q;
  logic [63:0] now_q;
  logic lst_q, syn_q, ack_q;
  logic [15:0] port_q, plen_q;
  logic [7:0] b0_q, b1_q, b5_q;

  logic adv, hit, free;
  logic [psfg_pkg::IdxW-1:0] hit_idx, free_idx, idx;
  psfg_pkg::entry_t ent_rd, ent_wr;
  logic take, wr, cap, tls, untr;
  logic [1:0] verd;
  logic [8:0] clen;

  assign adv = !out_valid_o || out_ready_i;
  assign in_ready_o = adv;

  always_comb begin
    hit = 1'b0;
    free = 1'b0;
    hit_idx = '0;
    free_idx = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (valid_q[i] && addr_q[i] == src_q) begin
        hit = 1'b1;
        hit_idx = psfg_pkg::IdxW'(i);
      end
      if (!valid_q[i]) begin
        free = 1'b1;
        free_idx = psfg_pkg::IdxW'(i);
      end
    end
    idx = hit ? hit_idx : free_idx;
    ent_rd = ent_q[idx];
  end

  psfg_update u_upd (
    .cfg_i(cfg_q), .kind_i(kind_q), .now_i(now_q), .listed_i(lst_q),
    .syn_i(syn_q), .ack_i(ack_q), .port_i(port_q), .plen_i(plen_q),
    .b0_i(b0_q), .b1_i(b1_q), .b5_i(b5_q), .hit_i(hit), .free_i(free),
    .ent_i(ent_rd), .take_o(take), .wr_o(wr), .ent_o(ent_wr),
    .verdict_o(verd), .capture_o(cap), .cap_len_o(clen), .tls_o(tls),
    .untracked_o(untr)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{syn_window_ns: 32'd1000000000, syn_limit: 16'd50,
                 bucket_capacity: 16'd200, refill_rate: 8'd1, packet_cost: 16'd4,
                 guarded_port_a: 16'd80, guarded_port_b: 16'd443};
      valid_q <= '0;
      s1_q <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          psfg_pkg::RegSynWindow:  cfg_q.syn_window_ns <= cfg_data_i;
          psfg_pkg::RegSynLimit:   cfg_q.syn_limit <= cfg_data_i[15:0];
          psfg_pkg::RegCapacity:   cfg_q.bucket_capacity <= cfg_data_i[15:0];
          psfg_pkg::RegRefillRate: cfg_q.refill_rate <= cfg_data_i[7:0];
          psfg_pkg::RegPacketCost: cfg_q.packet_cost <= cfg_data_i[15:0];
          psfg_pkg::RegPortA:      cfg_q.guarded_port_a <= cfg_data_i[15:0];
          psfg_pkg::RegPortB:      cfg_q.guarded_port_b <= cfg_data_i[15:0];
          default: ;
        endcase
      end
      if (adv) begin
        s1_q <= in_valid_i;
        out_valid_o <= s1_q;
        if (s1_q && take) valid_q[idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (in_valid_i) begin
        kind_q <= packet_kind_i;
        src_q <= src_addr_i;
        now_q <= time_ns_i;
        lst_q <= listed_i;
        syn_q <= syn_flag_i;
        ack_q <= ack_flag_i;
        port_q <= dst_port_i;
        plen_q <= payload_len_i;
        b0_q <= payload_byte0_i;
        b1_q <= payload_byte1_i;
        b5_q <= payload_byte5_i;
      end
      if (s1_q) begin
        verdict_o <= verd;
        capture_o <= cap;
        capture_len_o <= clen;
        tls_hello_o <= tls;
        untracked_o <= untr;
        if (take) addr_q[idx] <= src_q;
        if (wr) ent_q[idx] <= ent_wr;
      end
    end
  end
endmodule

// ----- tb/per_source_flood_guard_tb.sv -----
// Testbench for per_source_flood_guard: directed table plus random headers, checked by a predictor.
module per_source_flood_guard_tb;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] src;
    logic [63:0] stamp;
    logic        listed;
    logic        syn;
    logic        ack;
    logic [15:0] port;
    logic [15:0] plen;
    logic [7:0]  b0;
    logic [7:0]  b1;
    logic [7:0]  b5;
  } hdr_t;

  typedef struct packed {
    logic [1:0] verdict;
    logic       capture;
    logic [8:0] clen;
    logic       tls;
    logic       untracked;
  } verdict_t;

  typedef struct packed {
    logic     known;
    hdr_t     hdr;
    verdict_t res;
  } dir_row_t;

  localparam int unsigned IdleLimit = 4000;
  localparam int unsigned DirRows = 16;
  localparam int unsigned PhaseItems = 60;
  localparam int unsigned NumPhases = 7;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [31:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [1:0]  packet_kind_i;
  logic [31:0] src_addr_i;
  logic [63:0] time_ns_i;
  logic        listed_i;
  logic        syn_flag_i;
  logic        ack_flag_i;
  logic [15:0] dst_port_i;
  logic [15:0] payload_len_i;
  logic [7:0]  payload_byte0_i;
  logic [7:0]  payload_byte1_i;
  logic [7:0]  payload_byte5_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [1:0]  verdict_o;
  logic        capture_o;
  logic [8:0]  capture_len_o;
  logic        tls_hello_o;
  logic        untracked_o;

  per_source_flood_guard u_dut (.*);

  // predictor state
  psfg_pkg::cfg_t shadow_cfg;
  logic        src_valid   [psfg_pkg::TableEntries];
  logic [31:0] src_key     [psfg_pkg::TableEntries];
  logic        src_banned  [psfg_pkg::TableEntries];
  logic        syn_open    [psfg_pkg::TableEntries];
  logic [15:0] syn_cnt     [psfg_pkg::TableEntries];
  logic [63:0] win_start   [psfg_pkg::TableEntries];
  logic        bkt_open    [psfg_pkg::TableEntries];
  logic [15:0] tokens      [psfg_pkg::TableEntries];
  logic [63:0] refill_at   [psfg_pkg::TableEntries];

  verdict_t    pending_verdicts[$];
  dir_row_t    dir_tab[DirRows];
  int unsigned mismatches;
  int unsigned idle_cycles;
  int unsigned stall_left;
  logic        calm;
  logic [63:0] clock_ns;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic verdict_t judge(hdr_t h);
    verdict_t    r;
    int          e;
    logic        new_syn;
    logic        guarded;
    logic [63:0] tok;
    logic [63:0] el;
    r = '0;
    e = -1;
    if (h.listed) begin
      r.verdict = psfg_pkg::VerdictBanned;
    end else if (h.kind == psfg_pkg::KindNonTcp || h.kind == psfg_pkg::KindTcp) begin
      for (int i = 0; i < psfg_pkg::TableEntries; i++)
        if (e < 0 && src_valid[i] && src_key[i] == h.src) e = i;
      if (e >= 0 && src_banned[e]) r.verdict = psfg_pkg::VerdictBanned;
    end
    if (r.verdict == psfg_pkg::VerdictPass && h.kind == psfg_pkg::KindTcp) begin
      new_syn = h.syn && !h.ack;
      guarded = (h.port == shadow_cfg.guarded_port_a) || (h.port == shadow_cfg.guarded_port_b);
      if (e < 0 && (new_syn || guarded)) begin
        for (int i = 0; i < psfg_pkg::TableEntries; i++)
          if (e < 0 && !src_valid[i]) begin
            e = i;
            src_valid[i] = 1'b1;
            src_key[i] = h.src;
            src_banned[i] = 1'b0;
            syn_open[i] = 1'b0;
            syn_cnt[i] = '0;
            win_start[i] = '0;
            bkt_open[i] = 1'b0;
            tokens[i] = '0;
            refill_at[i] = '0;
          end
        if (e < 0) r.untracked = 1'b1;
      end
      if (e >= 0 && new_syn) begin
        if (syn_open[e]) begin
          if (h.stamp - win_start[e] > {32'd0, shadow_cfg.syn_window_ns}) begin
            syn_cnt[e] = 16'd1;
            win_start[e] = h.stamp;
          end else begin
            if (syn_cnt[e] != 16'hFFFF) syn_cnt[e]++;
            if (syn_cnt[e] > shadow_cfg.syn_limit) begin
              src_banned[e] = 1'b1;
              r.verdict = psfg_pkg::VerdictSynBan;
            end
          end
        end else begin
          syn_open[e] = 1'b1;
          syn_cnt[e] = 16'd1;
          win_start[e] = h.stamp;
        end
      end
      if (r.verdict == psfg_pkg::VerdictPass && e >= 0 && guarded) begin
        if (bkt_open[e]) begin
          el = h.stamp - refill_at[e];
          if (shadow_cfg.refill_rate == 8'd0) tok = 64'(tokens[e]);
          else if (el > 64'hFFFF) tok = 64'(shadow_cfg.bucket_capacity);
          else tok = 64'(tokens[e]) + el * 64'(shadow_cfg.refill_rate);
          if (tok > 64'(shadow_cfg.bucket_capacity)) tok = 64'(shadow_cfg.bucket_capacity);
          refill_at[e] = h.stamp;
          if (tok < 64'(shadow_cfg.packet_cost)) begin
            tokens[e] = tok[15:0];
            r.verdict = psfg_pkg::VerdictNoTok;
          end else begin
            tokens[e] = tok[15:0] - shadow_cfg.packet_cost;
          end
        end else begin
          bkt_open[e] = 1'b1;
          tokens[e] = (shadow_cfg.bucket_capacity > shadow_cfg.packet_cost) ?
                      shadow_cfg.bucket_capacity - shadow_cfg.packet_cost : 16'd0;
          refill_at[e] = h.stamp;
        end
      end
      if (r.verdict == psfg_pkg::VerdictPass && guarded &&
          h.plen > psfg_pkg::MinCapturePayload) begin
        r.capture = 1'b1;
        r.clen = (h.plen > 16'(psfg_pkg::CaptureMax)) ? 9'(psfg_pkg::CaptureMax) :
                 h.plen[8:0];
        r.tls = (h.port == shadow_cfg.guarded_port_b) && h.b0 == psfg_pkg::TlsHandshake &&
                h.b1 == psfg_pkg::TlsMajor && h.b5 == psfg_pkg::TlsHello;
      end
    end
    if (r.verdict != psfg_pkg::VerdictPass) r = '{verdict: r.verdict, default: '0};
    return r;
  endfunction

  function automatic dir_row_t row(logic known, logic [1:0] kind, logic [31:0] src,
                                   logic [63:0] stamp, logic listed, logic syn, logic ack,
                                   logic [15:0] port, logic [15:0] plen, logic tls_bytes,
                                   logic [1:0] verdict);
    dir_row_t d;
    d = '0;
    d.known = known;
    d.hdr = '{kind, src, stamp, listed, syn, ack, port, plen,
              tls_bytes ? psfg_pkg::TlsHandshake : 8'hFF,
              tls_bytes ? psfg_pkg::TlsMajor : 8'hFF,
              tls_bytes ? psfg_pkg::TlsHello : 8'hFF};
    d.res.verdict = verdict;
    return d;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (calm || r < 12) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  function automatic hdr_t random_hdr();
    hdr_t        h;
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) clock_ns = {$urandom, $urandom};
    else if (r == 1) clock_ns = clock_ns - 64'($urandom_range(1, 100));
    else if (r == 2) clock_ns = clock_ns + 64'($urandom_range(1000, 100000));
    else clock_ns = clock_ns + 64'($urandom_range(0, 40));
    h.stamp = clock_ns;
    h.kind = ($urandom_range(0, 9) < 8) ? psfg_pkg::KindTcp : 2'($urandom_range(0, 3));
    h.listed = ($urandom_range(0, 15) == 0);
    h.src = ($urandom_range(0, 7) == 0) ? $urandom :
            {$urandom_range(0, 1) ? 8'hFF : 8'h0A, 18'h0, 6'($urandom_range(0, 47))};
    h.syn = 1'($urandom_range(0, 1));
    h.ack = ($urandom_range(0, 9) < 3);
    r = $urandom_range(0, 9);
    h.port = (r < 4) ? shadow_cfg.guarded_port_a : (r < 8) ? shadow_cfg.guarded_port_b :
             16'($urandom);
    r = $urandom_range(0, 2);
    h.plen = (r == 0) ? 16'($urandom_range(0, 20)) : (r == 1) ? 16'($urandom) :
             16'($urandom_range(0, 400));
    if ($urandom_range(0, 3) == 0) begin
      h.b0 = psfg_pkg::TlsHandshake;
      h.b1 = psfg_pkg::TlsMajor;
      h.b5 = psfg_pkg::TlsHello;
    end else begin
      h.b0 = 8'($urandom);
      h.b1 = 8'($urandom);
      h.b5 = 8'($urandom);
    end
    return h;
  endfunction

  task automatic send(hdr_t h, logic known, verdict_t typed);
    verdict_t    p;
    int unsigned gap;
    in_valid_i <= 1'b1;
    packet_kind_i <= h.kind;
    src_addr_i <= h.src;
    time_ns_i <= h.stamp;
    listed_i <= h.listed;
    syn_flag_i <= h.syn;
    ack_flag_i <= h.ack;
    dst_port_i <= h.port;
    payload_len_i <= h.plen;
    payload_byte0_i <= h.b0;
    payload_byte1_i <= h.b1;
    payload_byte5_i <= h.b5;
    do @(posedge clk_i); while (!in_ready_o);
    p = judge(h);
    pending_verdicts.push_back(known ? typed : p);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic [2:0] idx, logic [31:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    case (idx)
      psfg_pkg::RegSynWindow:  shadow_cfg.syn_window_ns = val;
      psfg_pkg::RegSynLimit:   shadow_cfg.syn_limit = val[15:0];
      psfg_pkg::RegCapacity:   shadow_cfg.bucket_capacity = val[15:0];
      psfg_pkg::RegRefillRate: shadow_cfg.refill_rate = val[7:0];
      psfg_pkg::RegPacketCost: shadow_cfg.packet_cost = val[15:0];
      psfg_pkg::RegPortA:      shadow_cfg.guarded_port_a = val[15:0];
      psfg_pkg::RegPortB:      shadow_cfg.guarded_port_b = val[15:0];
      default: ;
    endcase
  endtask

  task automatic load_cfg(logic [31:0] win, logic [15:0] lim, logic [15:0] cap,
                          logic [7:0] rate, logic [15:0] cost, logic [15:0] pa,
                          logic [15:0] pb);
    write_cfg(psfg_pkg::RegSynWindow, win);
    write_cfg(psfg_pkg::RegSynLimit, {16'd0, lim});
    write_cfg(psfg_pkg::RegCapacity, {16'd0, cap});
    write_cfg(psfg_pkg::RegRefillRate, {24'd0, rate});
    write_cfg(psfg_pkg::RegPacketCost, {16'd0, cost});
    write_cfg(psfg_pkg::RegPortA, {16'd0, pa});
    write_cfg(psfg_pkg::RegPortB, {16'd0, pb});
    cfg_we_i <= 1'b0;
  endtask

  // result side: random stalls, checking and watchdog
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_left <= 0;
      idle_cycles <= 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (pending_verdicts.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected transaction: verdict %0d", verdict_o);
        end else begin
          verdict_t x;
          x = pending_verdicts.pop_front();
          if (x.verdict != verdict_o || x.capture != capture_o || x.clen != capture_len_o ||
              x.tls != tls_hello_o || x.untracked != untracked_o) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp v%0d c%0d l%0d t%0d u%0d got v%0d c%0d l%0d t%0d u%0d",
                       x.verdict, x.capture, x.clen, x.tls, x.untracked, verdict_o,
                       capture_o, capture_len_o, tls_hello_o, untracked_o);
          end
        end
      end
      if (stall_left > 0) begin
        out_ready_i <= 1'b0;
        stall_left <= stall_left - 1;
      end else begin
        out_ready_i <= 1'b1;
        stall_left <= calm ? 0 : ($urandom_range(0, 19) < 12) ? 0 :
                      ($urandom_range(0, 7) < 6) ? $urandom_range(1, 3) :
                      $urandom_range(10, 40);
      end
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i)
        idle_cycles <= 0;
      else if (in_valid_i || pending_verdicts.size() != 0)
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("per_source_flood_guard_tb failed");
        $finish;
      end
    end
  end

  initial begin
    verdict_t zero_v;
    zero_v = '0;
    mismatches = 0;
    calm = 1'b0;
    clock_ns = 64'd1000;
    shadow_cfg = '{32'd1000000000, 16'd50, 16'd200, 8'd1, 16'd4, 16'd80, 16'd443};
    foreach (src_valid[i]) src_valid[i] = 1'b0;
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= psfg_pkg::RegSynWindow;
    cfg_data_i <= '0;
    in_valid_i <= 1'b0;
    packet_kind_i <= '0;
    src_addr_i <= '0;
    time_ns_i <= '0;
    listed_i <= 1'b0;
    syn_flag_i <= 1'b0;
    ack_flag_i <= 1'b0;
    dst_port_i <= '0;
    payload_len_i <= '0;
    payload_byte0_i <= '0;
    payload_byte1_i <= '0;
    payload_byte5_i <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    dir_tab[0]  = row(1'b1, 2'd0, 32'h0A000001, 64'd10, 1'b0, 1'b1, 1'b0, 16'd80, 16'd100,
                      1'b1, psfg_pkg::VerdictPass);
    dir_tab[1]  = row(1'b1, 2'd3, 32'h0A000001, 64'd11, 1'b0, 1'b1, 1'b0, 16'd443, 16'd100,
                      1'b1, psfg_pkg::VerdictPass);
    dir_tab[2]  = row(1'b1, 2'd0, 32'h0A000002, 64'd12, 1'b1, 1'b0, 1'b0, 16'd80, 16'd50,
                      1'b0, psfg_pkg::VerdictBanned);
    dir_tab[3]  = row(1'b1, psfg_pkg::KindTcp, 32'h0A000002, 64'd13, 1'b1, 1'b1, 1'b0,
                      16'd443, 16'd50, 1'b1, psfg_pkg::VerdictBanned);
    dir_tab[4]  = row(1'b1, psfg_pkg::KindNonTcp, 32'h0A000003, 64'd14, 1'b0, 1'b0, 1'b0,
                      16'd80, 16'd90, 1'b0, psfg_pkg::VerdictPass);
    dir_tab[5]  = row(1'b0, psfg_pkg::KindTcp, 32'h0A000003, 64'd1000, 1'b0, 1'b1, 1'b0,
                      16'd80, 16'd100, 1'b0, psfg_pkg::VerdictPass);
    dir_tab[6]  = row(1'b0, psfg_pkg::KindTcp, 32'h0A000003, 64'd1001, 1'b0, 1'b1, 1'b1,
                      16'd443, 16'd300, 1'b1, psfg_pkg::VerdictPass);
    dir_tab[7]  = row(1'b0, psfg_pkg::KindTcp, 32'h0A000003, 64'd1002, 1'b0, 1'b0, 1'b1,
                      16'd443, 16'd11, 1'b1, psfg_pkg::VerdictPass);
    dir_tab[8]  = row(1'b0, psfg_pkg::KindTcp, 32'h0A000003, 64'd1003, 1'b0, 1'b0, 1'b0,
                      16'd80, 16'd10, 1'b0, psfg_pkg::VerdictPass);
    dir_tab[9]  = row(1'b0, psfg_pkg::KindTcp, 32'h0A000003, 64'd5, 1'b0, 1'b0, 1'b0,
                      16'd80, 16'd200, 1'b0, psfg_pkg::VerdictPass);
    dir_tab[10] = row(1'b0, psfg_pkg::KindTcp, 32'hFFFFFFFF, 64'hFFFFFFFFFFFFFFFF, 1'b0,
                      1'b1, 1'b1, 16'hFFFF, 16'hFFFF, 1'b0, psfg_pkg::VerdictPass);
    dir_tab[11] = row(1'b0, psfg_pkg::KindTcp, 32'h00000000, 64'd0, 1'b0, 1'b1, 1'b0,
                      16'd443, 16'hFFFF, 1'b1, psfg_pkg::VerdictPass);
    dir_tab[12] = row(1'b0, psfg_pkg::KindTcp, 32'h0A000004, 64'd2000, 1'b0, 1'b0, 1'b0,
                      16'd1234, 16'd500, 1'b1, psfg_pkg::VerdictPass);
    dir_tab[13] = row(1'b0, psfg_pkg::KindNonTcp, 32'h0A000003, 64'd2001, 1'b0, 1'b1, 1'b0,
                      16'd80, 16'd40, 1'b0, psfg_pkg::VerdictPass);
    dir_tab[14] = row(1'b0, psfg_pkg::KindTcp, 32'h00000000, 64'd3000000000, 1'b0, 1'b1,
                      1'b0, 16'd80, 16'd257, 1'b0, psfg_pkg::VerdictPass);
    dir_tab[15] = row(1'b0, psfg_pkg::KindTcp, 32'h00000000, 64'd3000000001, 1'b0, 1'b1,
                      1'b0, 16'd80, 16'd256, 1'b0, psfg_pkg::VerdictPass);
    for (int i = 0; i < DirRows; i++) begin
      zero_v.verdict = dir_tab[i].res.verdict;
      send(dir_tab[i].hdr, dir_tab[i].known, zero_v);
    end

    for (int p = 0; p < NumPhases; p++) begin
      settle();
      case (p)
        1: load_cfg(32'hFFFFFFFF, 16'd0, 16'hFFFF, 8'hFF, 16'd0, 16'd0, 16'hFFFF);
        2: load_cfg(32'd0, 16'd3, 16'd0, 8'd0, 16'hFFFF, 16'd80, 16'd443);
        3: load_cfg(32'd500, 16'hFFFF, 16'd50, 8'd1, 16'd10, 16'd443, 16'd443);
        4: load_cfg($urandom, 16'($urandom_range(0, 20)), 16'($urandom), 8'($urandom),
                    16'($urandom_range(0, 300)), 16'($urandom), 16'($urandom));
        5: load_cfg(32'd2000, 16'd2, 16'd20, 8'd2, 16'd5, 16'd80, 16'd443);
        6: load_cfg(32'd1000000000, 16'd50, 16'd200, 8'd1, 16'd4, 16'd80, 16'd443);
        default: ;
      endcase
      calm = (p == 3);
      for (int n = 0; n < PhaseItems; n++) send(random_hdr(), 1'b0, zero_v);
    end

    in_valid_i <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("per_source_flood_guard_tb passed");
    end else begin
      $display("per_source_flood_guard_tb failed");
    end
    $finish;
  end
endmodule

// ----- sim.f -----
rtl/core/psfg_pkg.sv
rtl/core/psfg_update.sv
rtl/core/per_source_flood_guard.sv
tb/per_source_flood_guard_tb.sv
